/* hw/rtl/fihm_pkg.sv */
// Shared constants, types and helpers of the fault injection hit matcher.
package fihm_pkg;

    // Sizing
    localparam int POINTS      = 16;
    localparam int LOG_DEPTH   = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_AW = $clog2(POINTS);
    localparam int LOG_AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FILL_W = $clog2(LOG_DEPTH + 1);
    localparam int PTR_W  = FILL_W + 1;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int POINT_W  = 4;
    localparam int CPU_W    = 8;
    localparam int THREAD_W = 32;
    localparam int LIMIT_W  = 5;
    localparam int ERROR_W  = 12;
    localparam int SHORT_W  = 16;
    localparam int SEQ_W    = 32;
    localparam int ORD_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT     = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_POINT = 8'd0,
        CFG_FAIL_AT      = 8'd1,
        CFG_MATCH_CPU    = 8'd2,
        CFG_ANY_CPU      = 8'd3,
        CFG_MATCH_THREAD = 8'd4,
        CFG_ANY_THREAD   = 8'd5,
        CFG_INJECT_ERROR = 8'd6,
        CFG_INJECT_SHORT = 8'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HIT,
        ST_READ,
        ST_ACK
    } state_t;

    typedef struct packed {
        logic [POINT_W-1:0]  target_point;
        logic [ORD_W-1:0]    fail_at;
        logic [CPU_W-1:0]    match_cpu;
        logic                any_cpu;
        logic [THREAD_W-1:0] match_thread;
        logic                any_thread;
        logic [ERROR_W-1:0]  inject_error;
        logic [SHORT_W-1:0]  inject_short;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        target_point: '0,
        fail_at:      ORD_W'(1),
        match_cpu:    '0,
        any_cpu:      1'b1,
        match_thread: '0,
        any_thread:   1'b1,
        inject_error: '0,
        inject_short: '0
    };

    typedef struct packed {
        logic [SEQ_W-1:0]    sequence_num;
        logic [ORD_W-1:0]    ordinal;
        logic [POINT_W-1:0]  point;
        logic [CPU_W-1:0]    cpu;
        logic [THREAD_W-1:0] thread_id;
        logic [ERROR_W-1:0]  error_code;
        logic [SHORT_W-1:0]  short_amount;
    } log_entry_t;

    typedef struct packed {
        logic                injected;
        logic [ERROR_W-1:0]  error_code;
        logic [SHORT_W-1:0]  short_amount;
        logic                entry_valid;
        logic [SEQ_W-1:0]    entry_sequence;
        logic [ORD_W-1:0]    entry_ordinal;
        logic [POINT_W-1:0]  entry_point;
        logic [CPU_W-1:0]    entry_cpu;
        logic [THREAD_W-1:0] entry_thread;
        logic [COUNT_W-1:0]  count_out;
        logic                last;
    } result_t;

    // Advance a ring slot, wrapping at the log depth
    function automatic logic [LOG_AW-1:0] ring_next(input logic [LOG_AW-1:0] slot);
        logic [LOG_AW-1:0] nxt;
        if (slot == LOG_AW'(LOG_DEPTH - 1))
            nxt = '0;
        else
            nxt = slot + LOG_AW'(1);
        return nxt;
    endfunction

endpackage

/* hw/rtl/fihm_if.sv */
// Valid/ready channel interfaces of the fault injection hit matcher.

interface fihm_item_if
    import fihm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [POINT_W-1:0]  point;
    logic [CPU_W-1:0]    cpu_id;
    logic [THREAD_W-1:0] thread_id;
    logic [LIMIT_W-1:0]  read_limit;

    modport source (output valid, kind, point, cpu_id, thread_id, read_limit, input ready);
    modport sink (input valid, kind, point, cpu_id, thread_id, read_limit, output ready);
endinterface

interface fihm_result_if
    import fihm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                injected;
    logic [ERROR_W-1:0]  error_code;
    logic [SHORT_W-1:0]  short_amount;
    logic                entry_valid;
    logic [SEQ_W-1:0]    entry_sequence;
    logic [ORD_W-1:0]    entry_ordinal;
    logic [POINT_W-1:0]  entry_point;
    logic [CPU_W-1:0]    entry_cpu;
    logic [THREAD_W-1:0] entry_thread;
    logic [COUNT_W-1:0]  count_out;
    logic                last;

    modport source (
        output valid, injected, error_code, short_amount, entry_valid, entry_sequence,
               entry_ordinal, entry_point, entry_cpu, entry_thread, count_out, last,
        input  ready
    );
    modport sink (
        input  valid, injected, error_code, short_amount, entry_valid, entry_sequence,
               entry_ordinal, entry_point, entry_cpu, entry_thread, count_out, last,
        output ready
    );
endinterface

interface fihm_cfg_if
    import fihm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/fault_injection_hit_matcher.sv */
// Fault injection hit matcher: per-point hit counters, match logic and injection ring log.
// Hit, restart, clear and empty read: one item at a time, with the result registered once
// the output slot is free; a hit is bound by the counter memory read plus its write-back.
// Log read of N entries: one entry per cycle while the result is not stalled.
// Reset (asynchronous, active low) and clear-all restore configuration, zero counters
// through per-point valid bits, and empty the log; no memory clearing pass.
module fault_injection_hit_matcher
    import fihm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    fihm_item_if.sink     item,
    fihm_result_if.source result,
    fihm_cfg_if.sink      cfg
);

    // Control state
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    cfg_regs_t          cfg_reg, cfg_next;
    logic [POINTS-1:0]  cnt_valid_reg, cnt_valid_next;
    logic [LOG_AW-1:0]  head_reg, head_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [COUNT_W-1:0] remain_reg, remain_next;

    // Item payload and read bookkeeping
    logic [POINT_W-1:0]  pt_reg, pt_next;
    logic [CPU_W-1:0]    cpu_reg, cpu_next;
    logic [THREAD_W-1:0] thr_reg, thr_next;
    logic                inrange_reg, inrange_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [LOG_AW-1:0]   slot_reg, slot_next;
    result_t             out_reg, out_next;

    // Memories
    logic [ORD_W-1:0] cnt_mem [POINTS];
    logic [ORD_W-1:0] cnt_rdata_reg;
    log_entry_t       log_mem [LOG_DEPTH];
    log_entry_t       log_rdata_reg;

    logic              cnt_re, cnt_we;
    logic [CNT_AW-1:0] cnt_raddr, cnt_waddr;
    logic              log_re, log_we;
    logic [LOG_AW-1:0] log_raddr;
    log_entry_t        log_wdata;

    logic accept, slot_free, out_load, hit_in_range;

    // Read setup
    logic [CMP_W-1:0]   lim_ext, fill_ext, min_cnt;
    logic [COUNT_W-1:0] rd_count;
    logic [PTR_W-1:0]   head_p, fill_p, first_p;
    logic [LOG_AW-1:0]  rd_first;

    // Hit evaluation
    logic [ORD_W-1:0] old_cnt, ord;
    logic             fresh, hit_inject;

    // Handshake qualifiers
    assign accept       = item.valid && item.ready;
    assign slot_free    = !out_valid_reg || result.ready;
    assign hit_in_range = (item.point != '0) && (32'(item.point) < 32'(POINTS));
    assign cnt_raddr    = CNT_AW'(item.point);
    assign cnt_waddr    = CNT_AW'(pt_reg);

    // Read count and oldest slot
    always_comb
    begin
        lim_ext  = CMP_W'(item.read_limit);
        fill_ext = CMP_W'(fill_reg);
        min_cnt  = (lim_ext < fill_ext) ? lim_ext : fill_ext;
        rd_count = (min_cnt > CMP_W'(MAX_RESULTS)) ? COUNT_W'(MAX_RESULTS) : COUNT_W'(min_cnt);
        head_p   = PTR_W'(head_reg);
        fill_p   = PTR_W'(fill_reg);
        if (fill_p > head_p)
            first_p = head_p + PTR_W'(LOG_DEPTH) - fill_p;
        else
            first_p = head_p - fill_p;
        rd_first = LOG_AW'(first_p);
    end

    // Counter update and match against configuration
    always_comb
    begin
        old_cnt    = cnt_valid_reg[cnt_waddr] ? cnt_rdata_reg : '0;
        fresh      = (old_cnt != '1);
        ord        = fresh ? old_cnt + ORD_W'(1) : old_cnt;
        hit_inject = inrange_reg && fresh
                     && (cfg_reg.target_point == pt_reg)
                     && (cfg_reg.fail_at == ord)
                     && (cfg_reg.any_cpu || (cfg_reg.match_cpu == cpu_reg))
                     && (cfg_reg.any_thread || (cfg_reg.match_thread == thr_reg));
    end

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    unique case (item.kind) inside
                        KIND_HIT:
                            state_next = ST_HIT;
                        KIND_READ:
                            state_next = (rd_count == '0) ? ST_ACK : ST_READ;
                        KIND_RESTART, KIND_CLEAR:
                            state_next = ST_ACK;
                        default:
                            state_next = ST_ACK;
                    endcase
                end
            end
            ST_HIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (slot_free && remain_reg == COUNT_W'(1))
                    state_next = ST_IDLE;
            end
            ST_ACK:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // FSM outputs: handshakes and memory read enables
    always_comb
    begin
        item.ready = (state_reg == ST_IDLE);
        cfg.ready  = 1'b1;
        out_load   = slot_free && (state_reg != ST_IDLE);
        cnt_re     = accept && (item.kind == KIND_HIT) && hit_in_range;
        log_re     = 1'b0;
        log_raddr  = slot_reg;
        if (accept && (item.kind == KIND_READ) && (rd_count != '0))
        begin
            log_re    = 1'b1;
            log_raddr = rd_first;
        end
        else if ((state_reg == ST_READ) && slot_free && (remain_reg > COUNT_W'(1)))
        begin
            log_re    = 1'b1;
            log_raddr = slot_reg;
        end
    end

    // Datapath next values
    always_comb
    begin
        cfg_next       = cfg_reg;
        cnt_valid_next = cnt_valid_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        seq_next       = seq_reg;
        remain_next    = remain_reg;
        pt_next        = pt_reg;
        cpu_next       = cpu_reg;
        thr_next       = thr_reg;
        inrange_next   = inrange_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        out_next       = out_reg;
        cnt_we         = 1'b0;
        log_we         = 1'b0;
        log_wdata      = '{
            sequence_num: seq_reg + SEQ_W'(1),
            ordinal:      ord,
            point:        pt_reg,
            cpu:          cpu_reg,
            thread_id:    thr_reg,
            error_code:   cfg_reg.inject_error,
            short_amount: cfg_reg.inject_short
        };

        // Configuration register writes
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TARGET_POINT: cfg_next.target_point = POINT_W'(cfg.data);
                CFG_FAIL_AT:      cfg_next.fail_at      = ORD_W'(cfg.data);
                CFG_MATCH_CPU:    cfg_next.match_cpu    = CPU_W'(cfg.data);
                CFG_ANY_CPU:      cfg_next.any_cpu      = cfg.data[0];
                CFG_MATCH_THREAD: cfg_next.match_thread = THREAD_W'(cfg.data);
                CFG_ANY_THREAD:   cfg_next.any_thread   = cfg.data[0];
                CFG_INJECT_ERROR: cfg_next.inject_error = ERROR_W'(cfg.data);
                CFG_INJECT_SHORT: cfg_next.inject_short = SHORT_W'(cfg.data);
                default:          cfg_next = cfg_reg;
            endcase
        end

        // Item transfer
        if (accept)
        begin
            unique case (item.kind) inside
                KIND_HIT:
                begin
                    pt_next      = item.point;
                    cpu_next     = item.cpu_id;
                    thr_next     = item.thread_id;
                    inrange_next = hit_in_range;
                end
                KIND_READ:
                begin
                    count_next  = rd_count;
                    remain_next = rd_count;
                    slot_next   = ring_next(rd_first);
                end
                KIND_RESTART:
                    cnt_valid_next = '0;
                KIND_CLEAR:
                begin
                    cfg_next       = CFG_RESET;
                    cnt_valid_next = '0;
                    head_next      = '0;
                    fill_next      = '0;
                    seq_next       = '0;
                end
                default:
                    cnt_valid_next = cnt_valid_reg;
            endcase
        end

        // Result generation
        if (out_load)
        begin
            out_next      = '0;
            out_next.last = 1'b1;
            case (state_reg)
                ST_HIT:
                begin
                    if (inrange_reg && fresh)
                    begin
                        cnt_we                    = 1'b1;
                        cnt_valid_next[cnt_waddr] = 1'b1;
                    end
                    if (hit_inject)
                    begin
                        log_we                = 1'b1;
                        seq_next              = seq_reg + SEQ_W'(1);
                        head_next             = ring_next(head_reg);
                        if (fill_reg < FILL_W'(LOG_DEPTH))
                            fill_next = fill_reg + FILL_W'(1);
                        out_next.injected     = 1'b1;
                        out_next.error_code   = cfg_reg.inject_error;
                        out_next.short_amount = cfg_reg.inject_short;
                    end
                end
                ST_READ:
                begin
                    out_next.entry_valid    = 1'b1;
                    out_next.error_code     = log_rdata_reg.error_code;
                    out_next.short_amount   = log_rdata_reg.short_amount;
                    out_next.entry_sequence = log_rdata_reg.sequence_num;
                    out_next.entry_ordinal  = log_rdata_reg.ordinal;
                    out_next.entry_point    = log_rdata_reg.point;
                    out_next.entry_cpu      = log_rdata_reg.cpu;
                    out_next.entry_thread   = log_rdata_reg.thread_id;
                    out_next.count_out      = count_reg;
                    out_next.last           = (remain_reg == COUNT_W'(1));
                    remain_next             = remain_reg - COUNT_W'(1);
                    if (remain_reg > COUNT_W'(1))
                        slot_next = ring_next(slot_reg);
                end
                default:
                    out_next.last = 1'b1;
            endcase
        end

        // Output register occupancy
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= CFG_RESET;
            cnt_valid_reg <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            seq_reg       <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            cnt_valid_reg <= cnt_valid_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
            remain_reg    <= remain_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pt_reg      <= pt_next;
        cpu_reg     <= cpu_next;
        thr_reg     <= thr_next;
        inrange_reg <= inrange_next;
        count_reg   <= count_next;
        slot_reg    <= slot_next;
        out_reg     <= out_next;
    end

    // Hit counter memory: read on transfer, written back in the HIT state once the slot is free
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= ord;
        if (cnt_re)
            cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // Injection log memory
    always_ff @(posedge clk)
    begin
        if (log_we)
            log_mem[head_reg] <= log_wdata;
        if (log_re)
            log_rdata_reg <= log_mem[log_raddr];
    end

    // Result channel
    assign result.valid          = out_valid_reg;
    assign result.injected       = out_reg.injected;
    assign result.error_code     = out_reg.error_code;
    assign result.short_amount   = out_reg.short_amount;
    assign result.entry_valid    = out_reg.entry_valid;
    assign result.entry_sequence = out_reg.entry_sequence;
    assign result.entry_ordinal  = out_reg.entry_ordinal;
    assign result.entry_point    = out_reg.entry_point;
    assign result.entry_cpu      = out_reg.entry_cpu;
    assign result.entry_thread   = out_reg.entry_thread;
    assign result.count_out      = out_reg.count_out;
    assign result.last           = out_reg.last;

`ifndef SYNTHESIS
    // An item transfer closes the input until that item is finished
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item channel still ready after a transfer");

    // Every injection takes the next sequence number
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HIT && out_load && hit_inject)
        |=> (seq_reg == $past(seq_reg) + SEQ_W'(1)))
        else $error("sequence counter did not advance on injection");

    // Ring pointers stay within the log
    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= FILL_W'(LOG_DEPTH)) && (head_reg <= LOG_AW'(LOG_DEPTH - 1)))
        else $error("ring head or fill out of range");
`endif

endmodule
